// ===== rtl/scmd_pkg.sv =====
// Shared types, constants and helper functions for the seconds counter display core.
`default_nettype none

package scmd_pkg;

  // Timing and limits
  localparam int unsigned PHASES_PER_SECOND = 40;
  localparam int unsigned NUM_DIGITS        = 5;
  localparam int unsigned PHASE_W           = 6;
  localparam int unsigned SECONDS_W         = 16;
  localparam int unsigned SEG_W             = 8;

  localparam logic [PHASE_W-1:0]   LAST_PHASE        = PHASE_W'(PHASES_PER_SECOND - 1);
  localparam logic [SECONDS_W-1:0] MAX_SECONDS_RESET = SECONDS_W'(43200);
  localparam logic [SECONDS_W-1:0] SECONDS_TOP       = '1;

  typedef logic [PHASE_W-1:0]   phase_t;
  typedef logic [SECONDS_W-1:0] seconds_t;
  typedef logic [SEG_W-1:0]     seg_t;
  typedef logic [3:0]           digit_t;
  // Decimal mirror of the seconds count, element 0 least significant
  typedef digit_t [NUM_DIGITS-1:0] bcd_t;

  // Active-low segment pattern, point bit (bit 7) off
  function automatic seg_t seg_code(input digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h98;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // Add one to a decimal count, ripple carry through the digits
  function automatic bcd_t bcd_inc(input bcd_t b);
    bcd_t r;
    logic carry;
    r     = b;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (b[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i]  = b[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scmd_display.sv =====
// Digit selection and segment encoding for the multiplexed display.
`default_nettype none

module scmd_display (
  input  wire scmd_pkg::bcd_t   digits,
  input  wire scmd_pkg::phase_t phase,
  output scmd_pkg::seg_t        segments
);
  import scmd_pkg::*;

  logic [2:0] ndig;
  logic [2:0] pos;
  logic [2:0] idx;
  digit_t     sel;

  // Number of significant digits, at least one
  always_comb begin
    priority if (digits[4] != 4'd0) begin
      ndig = 3'd5;
    end else if (digits[3] != 4'd0) begin
      ndig = 3'd4;
    end else if (digits[2] != 4'd0) begin
      ndig = 3'd3;
    end else if (digits[1] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  // Phase windows; position 1 is the most significant digit
  always_comb begin
    unique case (ndig)
      3'd1: pos = 3'd1;
      3'd2: pos = (phase <= 6'd19) ? 3'd1 : 3'd2;
      3'd3: pos = (phase <= 6'd8)  ? 3'd1 :
                  (phase <= 6'd24) ? 3'd2 : 3'd3;
      3'd4: pos = (phase <= 6'd10) ? 3'd1 :
                  (phase <= 6'd20) ? 3'd2 :
                  (phase <= 6'd30) ? 3'd3 : 3'd4;
      default: pos = (phase <= 6'd8)  ? 3'd1 :
                     (phase <= 6'd16) ? 3'd2 :
                     (phase <= 6'd24) ? 3'd3 :
                     (phase <= 6'd32) ? 3'd4 : 3'd5;
    endcase
  end

  // Position counted from the least significant end
  assign idx = ndig - pos;

  always_comb begin
    unique case (idx)
      3'd0:    sel = digits[0];
      3'd1:    sel = digits[1];
      3'd2:    sel = digits[2];
      3'd3:    sel = digits[3];
      3'd4:    sel = digits[4];
      default: sel = digits[0];
    endcase
  end

  assign segments = seg_code(sel);

endmodule

`default_nettype wire

// ===== rtl/seconds_counter_multiplexed_digit_core.sv =====
// Seconds counter with one multiplexed active-low 7-segment digit.
// Each accepted item passes the input register and then the output register, which part the channels.
// Throughput: one item per cycle while the output is not stalled.
// The seconds count is kept in binary and as a decimal mirror, so no digit division is needed.
// Reset (rst_n, synchronous, active low): phase and count to zero, limit to 43200, pipe empty.
`default_nettype none

module seconds_counter_multiplexed_digit_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire scmd_pkg::seconds_t cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_tick,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output scmd_pkg::seg_t          out_segments,
  output logic                    out_segments_valid
);
  import scmd_pkg::*;

  // Limit register
  seconds_t max_r;

  // Input stage
  logic s1_valid_r;
  logic s1_tick_r;

  // Counter state
  phase_t   phase_r, phase_nxt;
  seconds_t sec_r,   sec_nxt;
  bcd_t     bcd_r,   bcd_nxt;

  // Output stage
  logic out_valid_r;
  seg_t seg_r;
  logic segv_r;

  logic out_move;
  logic s1_move;
  logic in_accept;
  logic wrap;
  logic inc;
  logic show;
  seg_t seg_code_w;

  // Handshake
  assign out_move  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_move;
  assign in_stall  = s1_valid_r && !out_move;
  assign in_accept = in_valid && !in_stall;

  // Next counter state for a tick item
  assign wrap = (phase_r == LAST_PHASE);
  // Count rises on wrap until it sits one past the limit (or at the top)
  assign inc  = wrap && (sec_r <= max_r) && (sec_r != SECONDS_TOP);

  always_comb begin
    phase_nxt = phase_r;
    sec_nxt   = sec_r;
    bcd_nxt   = bcd_r;
    if (s1_tick_r) begin
      phase_nxt = wrap ? '0 : phase_r + PHASE_W'(1);
      if (inc) begin
        sec_nxt = sec_r + SECONDS_W'(1);
        bcd_nxt = bcd_inc(bcd_r);
      end
    end
  end

  // Display only for tick items, and only while the count is within the limit
  assign show = s1_tick_r && (sec_nxt <= max_r);

  scmd_display u_display (
    .digits   (bcd_nxt),
    .phase    (phase_nxt),
    .segments (seg_code_w)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_SECONDS_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      sec_r       <= '0;
      bcd_r       <= '0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (out_move) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        phase_r <= phase_nxt;
        sec_r   <= sec_nxt;
        bcd_r   <= bcd_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tick_r <= in_tick;
    end
    if (s1_move) begin
      seg_r  <= show ? seg_code_w : '0;
      segv_r <= show;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_segments       = seg_r;
  assign out_segments_valid = segv_r;

endmodule

`default_nettype wire

// ===== test/seconds_counter_multiplexed_digit_core_tb.sv =====
// Self-checking testbench for the seconds counter core: queued ticks in, predicted digit patterns out.
`timescale 1ns / 1ps

module seconds_counter_multiplexed_digit_core_tb;
  import scmd_pkg::*;

  localparam int unsigned TICKS_PER_SECOND = 40;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned CYCLE_LIMIT      = 100000;

  // Active-low glyphs for 0..9, point off
  localparam seg_t DIGIT_GLYPH [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                        8'h92, 8'h82, 8'hF8, 8'h80, 8'h98};

  typedef struct packed {
    seg_t segments;
    logic shown;
  } display_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  seconds_t cfg_wdata = '0;
  logic     in_valid  = 1'b0;
  logic     in_tick   = 1'b0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  seg_t     out_segments;
  logic     out_segments_valid;

  // Predicted state of the counter
  phase_t   clock_phase;
  seconds_t clock_seconds;
  seconds_t clock_limit;

  logic        pending_ticks[$];
  display_t    expected_displays[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_hold     = 0;
  int unsigned stall_mode     = 0;

  seconds_counter_multiplexed_digit_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tick            (in_tick),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_segments       (out_segments),
    .out_segments_valid (out_segments_valid)
  );

  always #5 clk = ~clk;

  // Advance the predicted counter by one item and work out the digit it shows
  function automatic display_t step_display(input logic tick);
    display_t    d;
    int unsigned ceiling;
    int unsigned value;
    int unsigned ndig;
    int unsigned pos;
    int unsigned ph;
    int unsigned dec [5];
    d.segments = '0;
    d.shown    = 1'b0;
    if (!tick) return d;

    if (clock_phase == phase_t'(TICKS_PER_SECOND - 1)) begin
      clock_phase = '0;
      ceiling = (clock_limit == SECONDS_TOP) ? 32'hFFFF : 32'(clock_limit) + 32'd1;
      if (32'(clock_seconds) < ceiling) clock_seconds = clock_seconds + 16'd1;
    end else begin
      clock_phase = clock_phase + 6'd1;
    end

    // count past the limit: display left alone
    if (clock_seconds > clock_limit) return d;

    value = 32'(clock_seconds);
    if (value <= 9) ndig = 1;
    else if (value <= 99) ndig = 2;
    else if (value <= 999) ndig = 3;
    else if (value <= 9999) ndig = 4;
    else ndig = 5;
    for (int i = 0; i < 5; i++) begin
      dec[i] = value % 10;
      value  = value / 10;
    end

    // phase windows, digit 1 the most significant
    ph = 32'(clock_phase);
    case (ndig)
      1: pos = 1;
      2: pos = (ph <= 19) ? 1 : 2;
      3: pos = (ph <= 8) ? 1 : ((ph <= 24) ? 2 : 3);
      4: pos = (ph <= 10) ? 1 : ((ph <= 20) ? 2 : ((ph <= 30) ? 3 : 4));
      default: begin
        if (ph <= 8) pos = 1;
        else if (ph <= 16) pos = 2;
        else if (ph <= 24) pos = 3;
        else if (ph <= 32) pos = 4;
        else pos = 5;
      end
    endcase
    d.segments = DIGIT_GLYPH[dec[ndig - pos]];
    d.shown    = 1'b1;
    return d;
  endfunction

  // Receiver stall pattern: switches between free, light and heavy stalling
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_hold <= $urandom_range(16, 255);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Driver: sends queued items in bursts with gaps, predicts on acceptance
  always @(posedge clk) begin
    logic taken;
    taken = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) expected_displays.push_back(step_display(in_tick));
      if (in_valid && !taken) begin
        // stalled: hold the item
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_tick  <= pending_ticks.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: each accepted result against the oldest prediction
  always @(posedge clk) begin
    display_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_displays.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected item: segments %h valid %b", out_segments, out_segments_valid);
      end else begin
        want = expected_displays.pop_front();
        if (out_segments !== want.segments || out_segments_valid !== want.shown) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_LIMIT)
            $display("mismatch: segments exp %h got %h, valid exp %b got %b",
                     want.segments, out_segments, want.shown, out_segments_valid);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("seconds_counter_multiplexed_digit_core verification failed");
      $finish;
    end
  end

  // Queue random ticks, pct percent of them set
  task automatic queue_ticks(input int unsigned count, input int unsigned pct);
    for (int unsigned i = 0; i < count; i++)
      pending_ticks.push_back($urandom_range(0, 99) < pct);
  endtask

  // Wait until every item is sent and every result has come back
  task automatic settle();
    while (pending_ticks.size() != 0 || in_valid || expected_displays.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input seconds_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clock_limit = value;
  endtask

  initial begin
    logic opening [20];
    opening = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    clock_phase   = '0;
    clock_seconds = '0;
    clock_limit   = MAX_SECONDS_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit: a fixed mix of idle items and ticks first, then ticks until the count has two digits
    foreach (opening[i]) pending_ticks.push_back(opening[i]);
    queue_ticks(410, 99);
    settle();

    // Limit lowered below the count: count holds, nothing shown
    write_limit(16'h0000);
    queue_ticks(30, 80);
    settle();

    // Limit equal to the count: shown, then saturation one past the limit
    write_limit(clock_seconds);
    queue_ticks(60, 95);
    settle();

    // Random limit, then the all-ones value
    write_limit(seconds_t'($urandom_range(0, 65535)));
    queue_ticks(20, 85);
    settle();
    write_limit(16'hFFFF);
    queue_ticks(20, 90);
    settle();

    if (mismatch_count == 0) begin
      $display("seconds_counter_multiplexed_digit_core verification clean");
    end else begin
      $display("seconds_counter_multiplexed_digit_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/scmd_pkg.sv
rtl/scmd_display.sv
rtl/seconds_counter_multiplexed_digit_core.sv
test/seconds_counter_multiplexed_digit_core_tb.sv
